// ----- rtl/core/trilinear_volume_sampler_macros.svh -----
// ---------------------------------------------------------------------------
// trilinear volume sampler assertion macros
// shared concurrent assertion forms for the sampler rtl
// ---------------------------------------------------------------------------
`ifndef TRILINEAR_VOLUME_SAMPLER_MACROS_SVH
`define TRILINEAR_VOLUME_SAMPLER_MACROS_SVH

// same-cycle implication, disabled during reset
`define TVS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define TVS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/tvs_pkg.sv -----
// ---------------------------------------------------------------------------
// tvs_pkg
// shared types, constants and helpers of the trilinear volume sampler
// ---------------------------------------------------------------------------
`default_nettype none

package tvs_pkg;

  localparam int MAX_DIM_DEF   = 64;
  localparam int FRAC_BITS_DEF = 8;

  // queue depths between front, back and the result port
  localparam int CMD_DEPTH = 4;
  localparam int OUT_DEPTH = 4;

  localparam logic CMD_SAMPLE = 1'b1;

  // configuration port
  localparam int CFG_ADDR_W = 5;
  localparam logic [2:0] REG_SIZE_X     = 3'd0;
  localparam logic [2:0] REG_SIZE_Y     = 3'd1;
  localparam logic [2:0] REG_SIZE_Z     = 3'd2;
  localparam logic [2:0] REG_OUTSIDE_RE = 3'd3;
  localparam logic [2:0] REG_OUTSIDE_IM = 3'd4;
  localparam logic [6:0] SIZE_RESET     = 7'd64;

  typedef struct packed {
    logic               cmd;
    logic [5:0]         vox_x;
    logic [5:0]         vox_y;
    logic [5:0]         vox_z;
    logic signed [15:0] val_re;
    logic signed [15:0] val_im;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] res_re;
    logic signed [15:0] res_im;
    logic               used_outside;
  } out_word_t;

  typedef struct packed {
    logic [6:0]         size_x;
    logic [6:0]         size_y;
    logic [6:0]         size_z;
    logic signed [15:0] outside_re;
    logic signed [15:0] outside_im;
  } cfg_t;

  typedef enum logic {
    BK_IDLE,
    BK_READ
  } bk_state_t;

  // width of one classified word in the command queue
  function automatic int tvs_item_width(int idx_w, int frac_w);
    return 40 + 9 * idx_w + 3 * frac_w;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/trilinear_volume_sampler.sv -----
// ---------------------------------------------------------------------------
// trilinear_volume_sampler
// complex voxel volume with trilinear sampling and an apb register port
// ---------------------------------------------------------------------------
// samples: a new sample starts its corner reads only once the eight corner reads of
//   the previous one are issued through the single-port volume memory; one voxel
//   write per cycle while no corner reads are in progress, no result word
// reset: registers return to sizes 64 and outside value 0; the volume memory
//   keeps its contents and needs no clearing pass
// ---------------------------------------------------------------------------
`default_nettype none

module trilinear_volume_sampler #(
  parameter int MAX_DIM   = tvs_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = tvs_pkg::FRAC_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // sample and voxel-write words
  input  wire logic                             item_valid,
  output logic                                  item_ready,
  input  wire tvs_pkg::in_word_t                item,
  // interpolated result words
  output logic                                  result_valid,
  input  wire logic                             result_ready,
  output tvs_pkg::out_word_t                    result,
  // register port
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [tvs_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                      pwdata,
  output logic      [31:0]                      prdata,
  output logic                                  pready
);

  import tvs_pkg::*;

  localparam int IDX_W  = $clog2(MAX_DIM);
  localparam int ITEM_W = tvs_item_width(IDX_W, FRAC_BITS);

  cfg_t              cfg;
  logic [2:0]        reg_idx;
  logic              reg_wr;
  // classified words from front to back
  logic              q_push_valid;
  logic              q_push_ready;
  logic [ITEM_W-1:0] q_push_data;
  logic              q_pop_valid;
  logic              q_pop_ready;
  logic [ITEM_W-1:0] q_pop_data;

  // ---- register port ----
  // word-aligned registers; index taken from the address above the byte bits
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign reg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.size_x     <= SIZE_RESET;
      cfg.size_y     <= SIZE_RESET;
      cfg.size_z     <= SIZE_RESET;
      cfg.outside_re <= '0;
      cfg.outside_im <= '0;
    end else if (reg_wr) begin
      unique case (reg_idx)
        REG_SIZE_X:     cfg.size_x     <= pwdata[6:0];
        REG_SIZE_Y:     cfg.size_y     <= pwdata[6:0];
        REG_SIZE_Z:     cfg.size_z     <= pwdata[6:0];
        REG_OUTSIDE_RE: cfg.outside_re <= pwdata[15:0];
        REG_OUTSIDE_IM: cfg.outside_im <= pwdata[15:0];
        default: ;  // addresses past the register list are ignored
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SIZE_X:     prdata = 32'(cfg.size_x);
      REG_SIZE_Y:     prdata = 32'(cfg.size_y);
      REG_SIZE_Z:     prdata = 32'(cfg.size_z);
      REG_OUTSIDE_RE: prdata = 32'(cfg.outside_re);
      REG_OUTSIDE_IM: prdata = 32'(cfg.outside_im);
      default:        prdata = '0;
    endcase
  end

  // ---- front: floor, fraction and bounds classification ----
  tvs_front #(
    .MAX_DIM  (MAX_DIM),
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item      (item),
    .cfg       (cfg),
    .push_valid(q_push_valid),
    .push_ready(q_push_ready),
    .push_data (q_push_data)
  );

  // ---- command queue: lets the front keep taking words during corner reads ----
  tvs_queue #(
    .WIDTH(ITEM_W),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_valid(q_push_valid),
    .push_ready(q_push_ready),
    .push_data (q_push_data),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_data  (q_pop_data)
  );

  // ---- back: volume memory, corner sequencer, blend pipeline, result fifo ----
  tvs_back #(
    .MAX_DIM  (MAX_DIM),
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .pop_valid   (q_pop_valid),
    .pop_ready   (q_pop_ready),
    .pop_data    (q_pop_data),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

endmodule

`default_nettype wire

// ----- rtl/core/tvs_queue.sv -----
// ---------------------------------------------------------------------------
// tvs_queue
// small register fifo with valid/ready on both sides
// ---------------------------------------------------------------------------
`default_nettype none

module tvs_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PTR_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic      [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             push_ok;
  logic             pop_ok;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = store[rptr];
  assign push_ok    = push_valid && push_ready;
  assign pop_ok     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push_ok) wptr <= wptr + PTR_W'(1);
      if (pop_ok) rptr <= rptr + PTR_W'(1);
      if (push_ok && !pop_ok) begin
        count <= count + CNT_W'(1);
      end else if (pop_ok && !push_ok) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) store[wptr] <= push_data;
  end

endmodule

`default_nettype wire

// ----- rtl/core/tvs_front.sv -----
// ---------------------------------------------------------------------------
// tvs_front
// accepts words, splits coordinates and classifies the eight neighbours
// ---------------------------------------------------------------------------
`default_nettype none

module tvs_front #(
  parameter int MAX_DIM   = tvs_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = tvs_pkg::FRAC_BITS_DEF,
  localparam int IDX_W  = $clog2(MAX_DIM),
  localparam int ITEM_W = tvs_pkg::tvs_item_width(IDX_W, FRAC_BITS)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire tvs_pkg::in_word_t item,
  input  wire tvs_pkg::cfg_t     cfg,
  output logic                   push_valid,
  input  wire logic              push_ready,
  output logic      [ITEM_W-1:0] push_data
);

  import tvs_pkg::*;

  typedef struct packed {
    logic                   sample;
    logic                   wr_ok;
    logic [3*IDX_W-1:0]     wr_addr;
    logic [31:0]            wr_data;
    logic [IDX_W-1:0]       ix0;
    logic [IDX_W-1:0]       ix1;
    logic [IDX_W-1:0]       iy0;
    logic [IDX_W-1:0]       iy1;
    logic [IDX_W-1:0]       iz0;
    logic [IDX_W-1:0]       iz1;
    logic [1:0]             in_x;
    logic [1:0]             in_y;
    logic [1:0]             in_z;
    logic [FRAC_BITS-1:0]   fx;
    logic [FRAC_BITS-1:0]   fy;
    logic [FRAC_BITS-1:0]   fz;
  } item_t;

  item_t       f_item;
  item_t       item_next;
  logic        f_valid;
  logic [16:0] x0, x1, y0, y1, z0, z1;

  // floor of a signed fixed-point coordinate, sign-extended by one bit
  function automatic logic [16:0] floor_idx(logic [15:0] pos);
    return 17'($signed(pos) >>> FRAC_BITS);
  endfunction

  function automatic logic in_range(logic [16:0] i, logic [6:0] size);
    return !i[16] && (i < 17'(size)) && (i < 17'(MAX_DIM));
  endfunction

  always_comb begin
    x0 = floor_idx(item.pos_x);
    y0 = floor_idx(item.pos_y);
    z0 = floor_idx(item.pos_z);
    x1 = x0 + 17'd1;
    y1 = y0 + 17'd1;
    z1 = z0 + 17'd1;

    item_next.sample  = (item.cmd == CMD_SAMPLE);
    item_next.wr_ok   = (32'(item.vox_x) < MAX_DIM) && (32'(item.vox_y) < MAX_DIM) &&
                        (32'(item.vox_z) < MAX_DIM);
    item_next.wr_addr = {IDX_W'(item.vox_z), IDX_W'(item.vox_y), IDX_W'(item.vox_x)};
    item_next.wr_data = {item.val_im, item.val_re};
    item_next.ix0     = x0[IDX_W-1:0];
    item_next.ix1     = x1[IDX_W-1:0];
    item_next.iy0     = y0[IDX_W-1:0];
    item_next.iy1     = y1[IDX_W-1:0];
    item_next.iz0     = z0[IDX_W-1:0];
    item_next.iz1     = z1[IDX_W-1:0];
    item_next.in_x    = {in_range(x1, cfg.size_x), in_range(x0, cfg.size_x)};
    item_next.in_y    = {in_range(y1, cfg.size_y), in_range(y0, cfg.size_y)};
    item_next.in_z    = {in_range(z1, cfg.size_z), in_range(z0, cfg.size_z)};
    item_next.fx      = item.pos_x[FRAC_BITS-1:0];
    item_next.fy      = item.pos_y[FRAC_BITS-1:0];
    item_next.fz      = item.pos_z[FRAC_BITS-1:0];
  end

  assign item_ready = !f_valid || push_ready;
  assign push_valid = f_valid;
  assign push_data  = f_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (item_ready) begin
      f_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) f_item <= item_next;
  end

endmodule

`default_nettype wire

// ----- rtl/core/tvs_back.sv -----
// ---------------------------------------------------------------------------
// tvs_back
// volume memory, corner read sequencer and separable blend pipeline
// ---------------------------------------------------------------------------
`default_nettype none
`include "trilinear_volume_sampler_macros.svh"

module tvs_back #(
  parameter int MAX_DIM   = tvs_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = tvs_pkg::FRAC_BITS_DEF,
  localparam int IDX_W  = $clog2(MAX_DIM),
  localparam int ITEM_W = tvs_pkg::tvs_item_width(IDX_W, FRAC_BITS)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tvs_pkg::cfg_t      cfg,
  input  wire logic               pop_valid,
  output logic                    pop_ready,
  input  wire logic  [ITEM_W-1:0] pop_data,
  output logic                    result_valid,
  input  wire logic               result_ready,
  output tvs_pkg::out_word_t      result
);

  import tvs_pkg::*;

  localparam int F         = FRAC_BITS;
  localparam int ADDR_W    = 3 * IDX_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam int PX_W      = 17 + F;
  localparam int PY_W      = 17 + 2 * F;
  localparam int PZ_W      = 17 + 3 * F;
  localparam int CRED_W    = $clog2(OUT_DEPTH + 1);
  localparam logic [F:0]      ONE_FX = (F + 1)'(1) << F;
  localparam logic [PZ_W-1:0] RND    = PZ_W'(1) << (3 * F - 1);

  typedef struct packed {
    logic                   sample;
    logic                   wr_ok;
    logic [3*IDX_W-1:0]     wr_addr;
    logic [31:0]            wr_data;
    logic [IDX_W-1:0]       ix0;
    logic [IDX_W-1:0]       ix1;
    logic [IDX_W-1:0]       iy0;
    logic [IDX_W-1:0]       iy1;
    logic [IDX_W-1:0]       iz0;
    logic [IDX_W-1:0]       iz1;
    logic [1:0]             in_x;
    logic [1:0]             in_y;
    logic [1:0]             in_z;
    logic [F-1:0]           fx;
    logic [F-1:0]           fy;
    logic [F-1:0]           fz;
  } item_t;

  item_t       head;
  item_t       cur;
  bk_state_t   state;
  bk_state_t   state_next;
  logic [2:0]  k;
  logic        credit_ok;
  logic        start;
  logic        do_wr;
  logic        mem_we;
  logic        rd_go;
  logic [ADDR_W-1:0] mem_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic        corner_in;
  logic [CRED_W-1:0] pending;
  logic [CRED_W-1:0] pending_next;
  logic        deliver;

  logic [31:0] mem [MEM_DEPTH];
  logic [31:0] rd_data;

  // stage registers: t1 read issued, t2 x products, t3 x pairs, t4 y products,
  // t5 y pairs, t6 z products, t7 final sum
  logic         t1_valid, t2_valid, t3_valid, t4_valid, t5_valid, t6_valid, t7_valid;
  logic [2:0]   t1_k, t2_k, t3_k, t4_k, t5_k, t6_k;
  logic         t1_in;
  logic         t2_out, t3_out, t4_out, t5_out, t6_out, t7_out;
  logic         h0_out, h1_out, h2_out;
  logic [F-1:0] t1_fx, t1_fy, t1_fz, t2_fy, t2_fz, t3_fy, t3_fz, t4_fz, t5_fz;
  logic signed [15:0]     v   [2];
  logic [F:0]             wx, wy, wz;
  logic signed [PX_W-1:0] px  [2];
  logic signed [PX_W-1:0] h0  [2];
  logic signed [PX_W-1:0] sa  [2];
  logic signed [PY_W-1:0] py  [2];
  logic signed [PY_W-1:0] h1  [2];
  logic signed [PY_W-1:0] sab [2];
  logic signed [PZ_W-1:0] pz  [2];
  logic signed [PZ_W-1:0] h2  [2];
  logic signed [PZ_W-1:0] tot [2];

  out_word_t              res_word;
  logic                   res_push_ready;
  logic [$bits(out_word_t)-1:0] res_bits;

  assign head = pop_data;

  // ---- sequencer ----
  assign credit_ok = (pending < CRED_W'(OUT_DEPTH));
  assign start     = ((state == BK_IDLE) || ((state == BK_READ) && (k == 3'd7))) &&
                     pop_valid && head.sample && credit_ok;
  assign do_wr     = (state == BK_IDLE) && pop_valid && !head.sample;
  assign rd_addr   = {(k[2] ? cur.iz1 : cur.iz0), (k[1] ? cur.iy1 : cur.iy0),
                      (k[0] ? cur.ix1 : cur.ix0)};
  assign corner_in = cur.in_x[k[0]] && cur.in_y[k[1]] && cur.in_z[k[2]];

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (start) state_next = BK_READ;
      BK_READ: if ((k == 3'd7) && !start) state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_ready = start || do_wr;
    mem_we    = do_wr && head.wr_ok;
    rd_go     = (state == BK_READ);
    mem_addr  = rd_go ? rd_addr : head.wr_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      k     <= 3'd0;
    end else begin
      state <= state_next;
      if (start) begin
        k <= 3'd0;
      end else if (state == BK_READ) begin
        k <= k + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) cur <= head;
  end

  // single-port volume memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= head.wr_data;
    rd_data <= mem[mem_addr];
  end

  // ---- result credits ----
  assign deliver = result_valid && result_ready;

  always_comb begin
    pending_next = pending;
    if (start && !deliver) begin
      pending_next = pending + CRED_W'(1);
    end else if (deliver && !start) begin
      pending_next = pending - CRED_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) pending <= '0;
    else pending <= pending_next;
  end

  // ---- blend pipeline ----
  always_comb begin
    v[0] = t1_in ? $signed(rd_data[15:0]) : cfg.outside_re;
    v[1] = t1_in ? $signed(rd_data[31:16]) : cfg.outside_im;
    wx   = t1_k[0] ? {1'b0, t1_fx} : ONE_FX - {1'b0, t1_fx};
    wy   = t3_k[1] ? {1'b0, t3_fy} : ONE_FX - {1'b0, t3_fy};
    wz   = t5_k[2] ? {1'b0, t5_fz} : ONE_FX - {1'b0, t5_fz};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_valid <= 1'b0;
      t2_valid <= 1'b0;
      t3_valid <= 1'b0;
      t4_valid <= 1'b0;
      t5_valid <= 1'b0;
      t6_valid <= 1'b0;
      t7_valid <= 1'b0;
    end else begin
      t1_valid <= rd_go;
      t2_valid <= t1_valid;
      t3_valid <= t2_valid && t2_k[0];
      t4_valid <= t3_valid;
      t5_valid <= t4_valid && t4_k[1];
      t6_valid <= t5_valid;
      t7_valid <= t6_valid && t6_k[2];
    end
  end

  always_ff @(posedge clk) begin
    t1_k  <= k;
    t1_in <= corner_in;
    t1_fx <= cur.fx;
    t1_fy <= cur.fy;
    t1_fz <= cur.fz;

    t2_k   <= t1_k;
    t2_out <= !t1_in;
    t2_fy  <= t1_fy;
    t2_fz  <= t1_fz;

    t3_k   <= t2_k;
    t3_out <= h0_out || t2_out;
    t3_fy  <= t2_fy;
    t3_fz  <= t2_fz;
    if (t2_valid && !t2_k[0]) h0_out <= t2_out;

    t4_k   <= t3_k;
    t4_out <= t3_out;
    t4_fz  <= t3_fz;

    t5_k   <= t4_k;
    t5_out <= h1_out || t4_out;
    t5_fz  <= t4_fz;
    if (t4_valid && !t4_k[1]) h1_out <= t4_out;

    t6_k   <= t5_k;
    t6_out <= t5_out;

    t7_out <= h2_out || t6_out;
    if (t6_valid && !t6_k[2]) h2_out <= t6_out;

    for (int l = 0; l < 2; l++) begin
      px[l]  <= $signed(PX_W'(v[l])) * $signed(PX_W'(wx));
      if (t2_valid && !t2_k[0]) h0[l] <= px[l];
      sa[l]  <= h0[l] + px[l];
      py[l]  <= $signed(PY_W'(sa[l])) * $signed(PY_W'(wy));
      if (t4_valid && !t4_k[1]) h1[l] <= py[l];
      sab[l] <= h1[l] + py[l];
      pz[l]  <= $signed(PZ_W'(sab[l])) * $signed(PZ_W'(wz));
      if (t6_valid && !t6_k[2]) h2[l] <= pz[l];
      tot[l] <= h2[l] + pz[l] + $signed(RND);
    end
  end

  // round-half-up shift by the weight fraction, low 16 bits kept
  always_comb begin
    res_word.res_re       = tot[0][3*F +: 16];
    res_word.res_im       = tot[1][3*F +: 16];
    res_word.used_outside = t7_out;
  end

  tvs_queue #(
    .WIDTH($bits(out_word_t)),
    .DEPTH(OUT_DEPTH)
  ) u_res_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_valid(t7_valid),
    .push_ready(res_push_ready),
    .push_data (res_word),
    .pop_valid (result_valid),
    .pop_ready (result_ready),
    .pop_data  (res_bits)
  );

  assign result = res_bits;

  `TVS_ASSERT_IMPL(a_res_room, clk, rst, t7_valid, res_push_ready, "result fifo overflow")
  `TVS_ASSERT_IMPL(a_credit_bound, clk, rst, 1'b1, pending <= CRED_W'(OUT_DEPTH), "credits exceeded")
  `TVS_ASSERT_IMPL(a_wr_idle, clk, rst, mem_we, state == BK_IDLE, "voxel write during corner reads")
  `TVS_ASSERT_NEXT(a_start_read, clk, rst, start, (state == BK_READ) && (k == 3'd0), "sample did not start")

endmodule

`default_nettype wire
